>>> rtl/core/tpr_pkg.sv
// tpr_pkg: shared types and constants of the trapezoidal position ramp
// holds the transfer structs, request and register codes and the sequencer states
// depends on nothing
package tpr_pkg;

	// fixed point format of positions and velocities
	localparam int FRAC_BITS = 16;
	localparam int POS_W     = 32;
	localparam int VEL_W     = 31;
	localparam int DT_BITS   = 16;
	localparam int CFG_W     = 31;
	localparam int IDX_W     = 2;

	// shift-add multiplier geometry
	localparam int MUL_W     = 32;
	localparam int MUL_CNT_W = $clog2(MUL_W);
	localparam int PROD_W    = 2 * MUL_W;
	localparam int RND_W     = POS_W + DT_BITS;

	// position hold window, round(1e-4 * 2^FRAC_BITS)
	localparam logic [POS_W-1:0] POS_EPS =
		POS_W'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
	localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (DT_BITS - 1);

	// request codes
	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_TARGET = 2'd1;
	localparam logic [1:0] REQ_START  = 2'd2;

	// register indexes
	localparam logic [IDX_W-1:0] CFG_MAX_VEL   = 2'd0;
	localparam logic [IDX_W-1:0] CFG_MAX_ACCEL = 2'd1;
	localparam logic [IDX_W-1:0] CFG_TICK_DT   = 2'd2;

	// register reset values
	localparam logic [VEL_W-1:0]   MAX_VEL_RST   = 31'd1966080;
	localparam logic [CFG_W-1:0]   MAX_ACCEL_RST = 31'd1966080;
	localparam logic [DT_BITS-1:0] TICK_DT_RST   = 16'd655;

	typedef struct packed {
		logic [1:0]              req_type;
		logic signed [POS_W-1:0] new_target;
		logic signed [POS_W-1:0] start_angle;
	} in_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] setpoint_pos;
		logic signed [POS_W-1:0] setpoint_vel;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_AE,
		ST_MUL_VV,
		ST_MUL_ADT,
		ST_VEL,
		ST_MUL_VDT,
		ST_POS,
		ST_OUT
	} state_t;

endpackage

>>> rtl/core/trapezoidal_position_ramp_unit.sv
// trapezoidal_position_ramp_unit: trapezoidal velocity profile generator, top level
// bit-serial shift-add multiplier, tick sequencer, state and output register
// depends on tpr_pkg
//
// usage
//   in channel (in_valid, in_stall, in_data): one transfer per request. a start
//   request loads position and target from the measured angle and zeroes the
//   velocity; a set-target request stores the new target. both act at the
//   transfer and produce no result. request code 3 is dropped without a result.
//   a tick request runs the ramp and produces exactly one result on the out
//   channel (out_valid, out_stall, out_data): the new position and velocity.
//   a tick runs on one shared shift-add multiplier that takes one multiplier
//   bit per cycle and forms four products in turn (a*|e|, v*v, a*dt, v*dt),
//   followed by the velocity update, position update and output load.
//   the unit takes one request at a time: in_stall is high while a tick is in
//   flight, so no new request is taken before a tick is through.
//   the output register holds a finished result under out_stall, and the next
//   request is taken meanwhile; a second tick waits in its output load cycle
//   until the held result has been transferred.
//   config writes (cfg_we, cfg_idx, cfg_wdata) are registered; the user must
//   write them only while idle, and the unit itself does not enforce it.
//   reset (arst_n low) restores the default limits, zeroes position, target and
//   velocity and empties the output register.
module trapezoidal_position_ramp_unit
	import tpr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0] cfg_wdata
);

	// registers
	state_t                  state_q, state_d;
	logic [VEL_W-1:0]        max_vel_q;
	logic [CFG_W-1:0]        max_accel_q;
	logic [DT_BITS-1:0]      tick_dt_q;
	logic signed [POS_W-1:0] target_q, ramp_pos_q, ramp_vel_q;

	// tick working values
	logic [POS_W-1:0]        ae_q;      // |error|
	logic                    e_neg_q, e_zero_q;
	logic [POS_W-1:0]        vmag_q;    // |velocity|, old then new
	logic [PROD_W-2:0]       m1_q;      // a * |e|
	logic [PROD_W-2:0]       m2_q;      // v * v
	logic                    brake_q;
	logic [POS_W-1:0]        step_q;    // a * dt rounded
	logic [POS_W-1:0]        dmag_q;    // |v| * dt rounded

	// shift-add multiplier
	logic [MUL_W-1:0]        mc_q;
	logic [MUL_W:0]          acc_hi_q;
	logic [MUL_W-1:0]        acc_lo_q;
	logic [MUL_CNT_W-1:0]    cnt_q;

	// output register
	out_item_t               out_q;
	logic                    out_valid_q;

	// control
	logic                    take, tick_take, mul_last, out_free, out_load;
	logic                    mul_active, mul_load;
	logic [MUL_W-1:0]        mc_c, mr_c;
	logic [MUL_W:0]          mul_sum;
	logic [PROD_W-1:0]       prod_next;
	logic [RND_W-1:0]        prod_rnd;
	logic signed [POS_W:0]   e_c;
	logic [POS_W-1:0]        ae_c, vmag_in_c;
	logic signed [POS_W+1:0] v_c, vmax_c;
	logic [POS_W-1:0]        vmag_new_c;
	logic signed [POS_W+1:0] pos_c;
	logic                    move_c;
	logic [PROD_W:0]         lhs_c;
	logic [POS_W-1:0]        vel_mag_c;

	assign take      = in_valid && !in_stall;
	assign tick_take = take && (in_data.req_type == REQ_TICK);
	assign mul_last  = (cnt_q == MUL_CNT_W'(MUL_W - 1));
	assign out_free  = !out_valid_q || !out_stall;

	// error and velocity magnitude at the tick transfer
	assign e_c       = {target_q[POS_W-1], target_q} - {ramp_pos_q[POS_W-1], ramp_pos_q};
	assign ae_c      = e_c[POS_W] ? POS_W'(-e_c) : e_c[POS_W-1:0];
	assign vmag_in_c = ramp_vel_q[POS_W-1] ? POS_W'(-ramp_vel_q) : POS_W'(ramp_vel_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (tick_take) state_d = ST_MUL_AE;
			ST_MUL_AE:  if (mul_last) state_d = ST_MUL_VV;
			ST_MUL_VV:  if (mul_last) state_d = ST_MUL_ADT;
			ST_MUL_ADT: if (mul_last) state_d = ST_VEL;
			ST_VEL:     state_d = ST_MUL_VDT;
			ST_MUL_VDT: if (mul_last) state_d = ST_POS;
			ST_POS:     state_d = ST_OUT;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall   = 1'b1;
		mul_active = 1'b0;
		mul_load   = 1'b0;
		out_load   = 1'b0;
		mc_c       = '0;
		mr_c       = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				mul_load = tick_take;
				mc_c     = {1'b0, max_accel_q};
				mr_c     = ae_c;
			end
			ST_MUL_AE: begin
				mul_active = 1'b1;
				mul_load   = mul_last;
				mc_c       = vmag_q;
				mr_c       = vmag_q;
			end
			ST_MUL_VV: begin
				mul_active = 1'b1;
				mul_load   = mul_last;
				mc_c       = {1'b0, max_accel_q};
				mr_c       = MUL_W'(tick_dt_q);
			end
			ST_MUL_ADT: mul_active = 1'b1;
			ST_VEL: begin
				mul_load = 1'b1;
				mc_c     = vmag_new_c;
				mr_c     = MUL_W'(tick_dt_q);
			end
			ST_MUL_VDT: mul_active = 1'b1;
			ST_OUT:     out_load = out_free;
			default:    in_stall = 1'b1;
		endcase
	end

	// one multiplier bit per cycle: add, then shift the pair right
	assign mul_sum   = acc_hi_q + (acc_lo_q[0] ? {1'b0, mc_q} : '0);
	assign prod_next = {mul_sum[MUL_W:1], mul_sum[0], acc_lo_q[MUL_W-1:1]};
	assign prod_rnd  = prod_next[RND_W-1:0] + RND_HALF;

	// velocity update: brake toward zero or accelerate toward the target, then clamp
	always_comb begin
		v_c = (POS_W+2)'(ramp_vel_q);
		if (brake_q) begin
			if (!ramp_vel_q[POS_W-1] && ramp_vel_q != '0) begin
				v_c = v_c - (POS_W+2)'(step_q);
				if (v_c < 0) v_c = '0;
			end else begin
				v_c = v_c + (POS_W+2)'(step_q);
				if (v_c > 0) v_c = '0;
			end
		end else if (!e_neg_q && !e_zero_q) begin
			v_c = v_c + (POS_W+2)'(step_q);
		end else begin
			v_c = v_c - (POS_W+2)'(step_q);
		end
		vmax_c = (POS_W+2)'(max_vel_q);
		if (v_c > vmax_c) v_c = vmax_c;
		else if (v_c < -vmax_c) v_c = -vmax_c;
	end
	assign vmag_new_c = v_c[POS_W+1] ? POS_W'(-v_c) : v_c[POS_W-1:0];

	// position update with saturation, held inside the window at rest
	assign move_c = (ramp_vel_q != '0) || (ae_q > POS_EPS);
	always_comb begin
		if (ramp_vel_q[POS_W-1])
			pos_c = (POS_W+2)'(ramp_pos_q) - (POS_W+2)'(dmag_q);
		else
			pos_c = (POS_W+2)'(ramp_pos_q) + (POS_W+2)'(dmag_q);
		if (pos_c > (POS_W+2)'(32'sh7fffffff))
			pos_c = (POS_W+2)'(32'sh7fffffff);
		else if (pos_c < -(POS_W+2)'(33'sh080000000))
			pos_c = -(POS_W+2)'(33'sh080000000);
	end

	// braking distance test 2*a*|e| <= v*v
	assign lhs_c = {1'b0, m1_q, 1'b0};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			max_vel_q   <= MAX_VEL_RST;
			max_accel_q <= MAX_ACCEL_RST;
			tick_dt_q   <= TICK_DT_RST;
			target_q    <= '0;
			ramp_pos_q  <= '0;
			ramp_vel_q  <= '0;
		end else begin
			state_q <= state_d;
			if (mul_load)
				cnt_q <= '0;
			else if (mul_active)
				cnt_q <= cnt_q + 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_MAX_VEL:   max_vel_q   <= cfg_wdata[VEL_W-1:0];
					CFG_MAX_ACCEL: max_accel_q <= cfg_wdata;
					CFG_TICK_DT:   tick_dt_q   <= cfg_wdata[DT_BITS-1:0];
					default:       ;
				endcase
			end
			// request handling at the transfer
			if (take) begin
				case (in_data.req_type)
					REQ_TARGET: target_q <= in_data.new_target;
					REQ_START: begin
						ramp_pos_q <= in_data.start_angle;
						target_q   <= in_data.start_angle;
						ramp_vel_q <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_VEL)
				ramp_vel_q <= v_c[POS_W-1:0];
			if (state_q == ST_POS && move_c)
				ramp_pos_q <= pos_c[POS_W-1:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (tick_take) begin
			ae_q     <= ae_c;
			e_neg_q  <= e_c[POS_W];
			e_zero_q <= (e_c == '0);
			vmag_q   <= vmag_in_c;
		end
		if (mul_load) begin
			mc_q     <= mc_c;
			acc_hi_q <= '0;
			acc_lo_q <= mr_c;
		end else if (mul_active) begin
			acc_hi_q <= {1'b0, mul_sum[MUL_W:1]};
			acc_lo_q <= {mul_sum[0], acc_lo_q[MUL_W-1:1]};
		end
		if (state_q == ST_MUL_AE && mul_last)
			m1_q <= prod_next[PROD_W-2:0];
		if (state_q == ST_MUL_VV && mul_last)
			m2_q <= prod_next[PROD_W-2:0];
		if (state_q == ST_MUL_ADT) begin
			brake_q <= (lhs_c <= {2'b00, m2_q}) &&
				(e_zero_q || vmag_q == '0 || (e_neg_q == ramp_vel_q[POS_W-1]));
			if (mul_last)
				step_q <= prod_rnd[RND_W-1:DT_BITS];
		end
		if (state_q == ST_VEL)
			vmag_q <= vmag_new_c;
		if (state_q == ST_MUL_VDT && mul_last)
			dmag_q <= prod_rnd[RND_W-1:DT_BITS];
		if (out_load) begin
			out_q.setpoint_pos <= ramp_pos_q;
			out_q.setpoint_vel <= ramp_vel_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	assign vel_mag_c = ramp_vel_q[POS_W-1] ? POS_W'(-ramp_vel_q) : POS_W'(ramp_vel_q);

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result shown without a finished tick");

	a_vel_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POS |-> vel_mag_c <= {1'b0, max_vel_q})
		else $error("velocity beyond limit after update");

	a_mul_start: assert property (@(posedge clk) disable iff (!arst_n)
		tick_take |=> cnt_q == '0 && state_q == ST_MUL_AE)
		else $error("multiplier not restarted at tick");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == ST_IDLE)
		else $error("output load lost");

endmodule

>>> verif/testbench.sv
// testbench: self-checking bench for the trapezoidal position ramp unit
// drives request, limit and stall traffic and predicts every setpoint bit for bit
// depends on tpr_pkg and trapezoidal_position_ramp_unit
module testbench
	import tpr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// request code and register index the unit leaves unused
	localparam logic [1:0]       REQ_SPARE  = 2'd3;
	localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

	// position hold window, round(1e-4 * 2^FRAC_BITS)
	localparam longint HOLD_WIN = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
	localparam logic [63:0] DT_HALF = 64'd1 << (DT_BITS - 1);
	localparam longint S32_TOP = 64'sd2147483647;
	localparam longint S32_BOT = -64'sd2147483648;

	// idle time after the last setpoint, longer than a tick, before any limit write
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES   = 600;
	localparam int RANDOM_REQS   = 800;
	localparam int PHASE_REQS    = 100;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	trapezoidal_position_ramp_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predicted state of the ramp and its limits
	logic signed [POS_W-1:0] mdl_target = '0;
	logic signed [POS_W-1:0] mdl_pos = '0;
	logic signed [POS_W-1:0] mdl_vel = '0;
	logic [VEL_W-1:0]        mdl_max_vel = MAX_VEL_RST;
	logic [CFG_W-1:0]        mdl_max_accel = MAX_ACCEL_RST;
	logic [DT_BITS-1:0]      mdl_tick_dt = TICK_DT_RST;

	in_item_t  req_fifo[$];    // requests waiting to be offered
	out_item_t setpoint_q[$];  // setpoints predicted but not yet seen

	int in_xfers = 0;          // input transfers seen by the monitor
	int in_used = 0;           // input transfers the driver has acted on
	bit calm = 1'b0;           // no idling on either side during this phase
	bit hold_req = 1'b0;       // asks the receiver for one long hold-off
	bit hold_done = 1'b0;      // the long hold-off has been started
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;

	int fail_count = 0;
	int reqs_made = 0;
	int ticks_sent = 0;
	int results_seen = 0;
	int settings_used = 0;

	// one request: a target or start updates the state, a tick runs the ramp: error,
	// braking test, velocity step and clamp, then the rounded position step with saturation
	task automatic predict_request(input in_item_t rq);
		longint err, aerr, vel, step, vmax, npos;
		logic [63:0] ae_u, avel, lhs, rhs, dmag;
		bit brake;
		out_item_t res;
		case (rq.req_type)
			REQ_TARGET: begin
				mdl_target = rq.new_target;
			end
			REQ_START: begin
				mdl_pos = rq.start_angle;
				mdl_target = rq.start_angle;
				mdl_vel = '0;
			end
			REQ_TICK: begin
				err = longint'(mdl_target) - longint'(mdl_pos);
				aerr = (err < 0) ? -err : err;
				ae_u = aerr;
				vel = longint'(mdl_vel);
				avel = (vel < 0) ? -vel : vel;
				// braking distance v^2/(2a) compared without a division
				lhs = (64'(mdl_max_accel) * ae_u) << 1;
				rhs = avel * avel;
				brake = (lhs <= rhs) && (err == 0 || vel == 0 || ((err > 0) == (vel > 0)));
				step = longint'((64'(mdl_max_accel) * 64'(mdl_tick_dt) + DT_HALF) >> DT_BITS);
				if (brake) begin
					// slow down, never through zero
					if (vel > 0) begin
						vel = vel - step;
						if (vel < 0)
							vel = 0;
					end else begin
						vel = vel + step;
						if (vel > 0)
							vel = 0;
					end
				end else if (err > 0) begin
					vel = vel + step;
				end else begin
					vel = vel - step;
				end
				vmax = longint'(mdl_max_vel);
				if (vel > vmax)
					vel = vmax;
				else if (vel < -vmax)
					vel = -vmax;
				mdl_vel = vel[POS_W-1:0];
				// at rest inside the hold window the position stays put
				if (vel != 0 || aerr > HOLD_WIN) begin
					avel = (vel < 0) ? -vel : vel;
					dmag = (avel * 64'(mdl_tick_dt) + DT_HALF) >> DT_BITS;
					npos = longint'(mdl_pos) + ((vel < 0) ? -longint'(dmag) : longint'(dmag));
					if (npos > S32_TOP)
						npos = S32_TOP;
					else if (npos < S32_BOT)
						npos = S32_BOT;
					mdl_pos = npos[POS_W-1:0];
				end
				res.setpoint_pos = mdl_pos;
				res.setpoint_vel = mdl_vel;
				setpoint_q.push_back(res);
				ticks_sent++;
			end
			default: begin
				// spare code, dropped by the unit
			end
		endcase
	endtask

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// idle run length: mostly none or short, now and then a long one
	function automatic int idle_run(input int long_max);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, long_max);
	endfunction

	// monitor: records input transfers into the predictor and checks output transfers
	always @(posedge clk) begin : observer
		out_item_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_xfers++;
				predict_request(in_data);
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (setpoint_q.size() == 0) begin
					log_failure($sformatf("setpoint with nothing expected: pos %h vel %h",
						out_data.setpoint_pos, out_data.setpoint_vel));
				end else begin
					want = setpoint_q.pop_front();
					if (want.setpoint_pos !== out_data.setpoint_pos ||
					    want.setpoint_vel !== out_data.setpoint_vel)
						log_failure($sformatf(
							"setpoint mismatch: pos exp %h got %h, vel exp %h got %h",
							want.setpoint_pos, out_data.setpoint_pos,
							want.setpoint_vel, out_data.setpoint_vel));
				end
			end
		end
	end

	// driver: offers queued requests on the falling edge, with random gaps between them
	always @(negedge clk) begin : feeder
		if (arst_n) begin
			// a stalled request stays as it is until its transfer
			if (!in_valid || in_used != in_xfers) begin
				in_used = in_xfers;
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (req_fifo.size() > 0) begin
					in_data <= req_fifo.pop_front();
					in_valid <= 1'b1;
					gap_left = idle_run(60);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall runs, plus one long hold-off counted here
	always @(negedge clk) begin : sink
		int run;
		if (arst_n) begin
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				run = idle_run(80);
				if (run > 0)
					stall_left = run - 1;
				out_stall <= (run > 0);
			end
		end
	end

	// limit write, one cycle on the falling edge; only called while the unit is idle
	task automatic write_limit(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MAX_VEL:   mdl_max_vel = val[VEL_W-1:0];
			CFG_MAX_ACCEL: mdl_max_accel = val;
			CFG_TICK_DT:   mdl_tick_dt = val[DT_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic set_limits(input logic [CFG_W-1:0] vel, input logic [CFG_W-1:0] acc,
			input logic [DT_BITS-1:0] dt);
		write_limit(CFG_MAX_VEL, vel);
		write_limit(CFG_MAX_ACCEL, acc);
		write_limit(CFG_TICK_DT, CFG_W'(dt));
		settings_used++;
	endtask

	task automatic push_req(input logic [1:0] kind, input logic [POS_W-1:0] tgt,
			input logic [POS_W-1:0] ang);
		in_item_t rq;
		rq.req_type = kind;
		rq.new_target = tgt;
		rq.start_angle = ang;
		req_fifo.push_back(rq);
		if (kind != REQ_SPARE)
			reqs_made++;
	endtask

	// wait until every request is through and every setpoint has come back,
	// then let the unit idle for SETTLE_CYCLES more
	task automatic settle();
		while (req_fifo.size() != 0 || in_valid || setpoint_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// start angles: mostly anywhere, sometimes hard against either end
	function automatic logic [POS_W-1:0] pick_angle();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'h7FFF_FFFF - $urandom_range(0, 255);
		if (r == 1)
			return 32'h8000_0000 + $urandom_range(0, 255);
		return $urandom();
	endfunction

	// target offsets: a few small ones around the hold window, the rest on every scale
	function automatic logic [POS_W-1:0] pick_offset();
		logic [POS_W-1:0] mag;
		if ($urandom_range(0, 9) < 2)
			return 32'($urandom_range(0, 18)) - 32'd9;
		mag = $urandom() >> $urandom_range(0, 31);
		return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
	endfunction

	// a well-formed move: start (usually), target, a run of ticks,
	// now and then a new target while moving
	task automatic queue_move();
		logic [POS_W-1:0] home, goal;
		int n;
		home = pick_angle();
		if ($urandom_range(0, 4) != 0)
			push_req(REQ_START, $urandom(), home);
		goal = home + pick_offset();
		push_req(REQ_TARGET, goal, $urandom());
		n = $urandom_range(3, 40);
		repeat (n) begin
			if ($urandom_range(0, 29) == 0)
				push_req(REQ_TARGET, goal + pick_offset(), $urandom());
			push_req(REQ_TICK, $urandom(), $urandom());
		end
	endtask

	// limits for one random phase, the extremes among them
	task automatic pick_limits(input int ph);
		case (ph % 6)
			1: set_limits(31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
			2: set_limits(31'd1, 31'd1, 16'd1);
			4: set_limits(31'($urandom() >> $urandom_range(1, 20)), '0,
				16'($urandom_range(1, 65535)));
			5: set_limits(31'($urandom()), 31'($urandom()), 16'($urandom_range(0, 65535)));
			default: set_limits(31'($urandom() >> $urandom_range(1, 20)),
				31'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 24)),
				16'($urandom_range(256, 65535)));
		endcase
	endtask

	initial begin : stimulus
		int ph;
		int phase_start;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default limits: tick before any start, spare code, hold window, a short move
		push_req(REQ_TICK, 32'h7FFF_FFFF, 32'h8000_0000);
		push_req(REQ_SPARE, $urandom(), $urandom());
		push_req(REQ_START, 32'h8000_0000, 32'h0001_0000);
		push_req(REQ_TARGET, 32'h0001_0005, 32'h7FFF_FFFF);
		push_req(REQ_TICK, $urandom(), $urandom());
		push_req(REQ_TICK, $urandom(), $urandom());
		push_req(REQ_TARGET, 32'h0011_0000, $urandom());
		push_req(REQ_TICK, $urandom(), $urandom());
		push_req(REQ_TICK, $urandom(), $urandom());
		settle();

		// widest limits: saturation of the position at both ends
		set_limits(31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
		write_limit(CFG_UNUSED, 31'($urandom()));
		push_req(REQ_START, $urandom(), 32'h7FFF_0000);
		push_req(REQ_TARGET, 32'h7FFF_FFFF, $urandom());
		push_req(REQ_TICK, $urandom(), $urandom());
		push_req(REQ_TICK, $urandom(), $urandom());
		push_req(REQ_START, $urandom(), 32'h8000_0100);
		push_req(REQ_TARGET, 32'h8000_0000, $urandom());
		push_req(REQ_TICK, $urandom(), $urandom());
		push_req(REQ_TICK, $urandom(), $urandom());
		settle();

		// zero acceleration and zero tick: velocity only moves by the clamp
		set_limits(31'd1966080, '0, '0);
		push_req(REQ_TARGET, 32'h0000_03E8, $urandom());
		push_req(REQ_TICK, $urandom(), $urandom());
		push_req(REQ_TICK, $urandom(), $urandom());
		push_req(REQ_START, $urandom(), 32'h0000_0000);
		push_req(REQ_TARGET, 32'h0000_03E8, $urandom());
		push_req(REQ_TICK, $urandom(), $urandom());
		settle();

		// random phases, each under its own limits
		ph = 0;
		phase_start = reqs_made;
		while (reqs_made - phase_start < RANDOM_REQS) begin
			pick_limits(ph);
			calm = (ph % 4 == 3);
			begin : fill
				int base;
				base = reqs_made;
				while (reqs_made - base < PHASE_REQS) begin
					if ($urandom_range(0, 4) == 0)
						push_req(2'($urandom_range(0, 3)), $urandom(), $urandom());
					else
						queue_move();
				end
			end
			// one long hold-off on the result side while requests keep coming
			if (ph == 1)
				hold_req = 1'b1;
			settle();
			ph++;
		end
		calm = 1'b0;

		$display("run covered %0d requests (%0d ticks) over %0d limit settings",
			reqs_made, ticks_sent, settings_used);
		$display("%0d setpoints compared, %0d failures", results_seen, fail_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog, several times the slowest correct run
	initial begin : watchdog
		#6ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/tpr_pkg.sv
rtl/core/trapezoidal_position_ramp_unit.sv
verif/testbench.sv
